### rtl/core/vass_pkg.sv
// Shared types, register codes and constants of the vehicle-actuated signal sequencer.
package vass_pkg;

  localparam int unsigned ROADS   = 3;
  localparam int unsigned SENSORS = 2 * ROADS;

  localparam int unsigned RANGE_W = 16;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned ROAD_W  = 2;
  localparam int unsigned PCAR_W  = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_BASE_MS      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_PER_CAR_MS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX_MS       = 8'd3;

  // register reset values
  localparam logic [RANGE_W-1:0] RST_PRESENCE_THRESHOLD = 16'd100;
  localparam logic [MS_W-1:0]    RST_GREEN_BASE_MS      = 32'd6666;
  localparam logic [PCAR_W-1:0]  RST_GREEN_PER_CAR_MS   = 16'd1333;
  localparam logic [MS_W-1:0]    RST_GREEN_MAX_MS       = 32'd33333;

  localparam logic [CNT_W-1:0]  CNT_FULL  = 8'd255;
  localparam logic [CNT_W-1:0]  CNT_EMPTY = 8'd0;

  // road codes
  localparam logic [ROAD_W-1:0] ROAD_0 = 2'd0;
  localparam logic [ROAD_W-1:0] ROAD_1 = 2'd1;
  localparam logic [ROAD_W-1:0] ROAD_2 = 2'd2;

  typedef struct packed {
    logic [RANGE_W-1:0] presence_threshold;
    logic [MS_W-1:0]    green_base_ms;
    logic [PCAR_W-1:0]  green_per_car_ms;
    logic [MS_W-1:0]    green_max_ms;
  } cfg_t;

  // captured sweep: presence per sensor (entry at even, exit at odd) and timestamp
  typedef struct packed {
    logic [SENSORS-1:0] present;
    logic [MS_W-1:0]    now_ms;
  } sweep_t;

  // handshake between the input register and the result stage
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

endpackage

### rtl/core/vass_if.sv
// Channel interfaces: sweep input, result output and configuration writes.
interface vass_in_if;
  logic                               valid;
  logic                               ready;
  logic [vass_pkg::RANGE_W-1:0]       range_road0_entry;
  logic [vass_pkg::RANGE_W-1:0]       range_road0_exit;
  logic [vass_pkg::RANGE_W-1:0]       range_road1_entry;
  logic [vass_pkg::RANGE_W-1:0]       range_road1_exit;
  logic [vass_pkg::RANGE_W-1:0]       range_road2_entry;
  logic [vass_pkg::RANGE_W-1:0]       range_road2_exit;
  logic [vass_pkg::MS_W-1:0]          now_ms;

  modport source (
    output valid, range_road0_entry, range_road0_exit, range_road1_entry,
           range_road1_exit, range_road2_entry, range_road2_exit, now_ms,
    input  ready
  );
  modport sink (
    input  valid, range_road0_entry, range_road0_exit, range_road1_entry,
           range_road1_exit, range_road2_entry, range_road2_exit, now_ms,
    output ready
  );
endinterface

interface vass_out_if;
  logic                               valid;
  logic                               ready;
  logic [vass_pkg::CNT_W-1:0]         cars_road0;
  logic [vass_pkg::CNT_W-1:0]         cars_road1;
  logic [vass_pkg::CNT_W-1:0]         cars_road2;
  logic [vass_pkg::ROAD_W-1:0]        green_road;
  logic                               switch_pulse;

  modport source (
    output valid, cars_road0, cars_road1, cars_road2, green_road, switch_pulse,
    input  ready
  );
  modport sink (
    input  valid, cars_road0, cars_road1, cars_road2, green_road, switch_pulse,
    output ready
  );
endinterface

interface vass_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [vass_pkg::CFG_IDX_W-1:0]     index;
  logic [vass_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/vehicle_actuated_signal_sequencer.sv
// Top level of the vehicle-actuated signal sequencer for three roads.
//
//   channel   dir   modport  payload
//   in_ch     in    sink     six 16-bit ranges, now_ms
//   out_ch    out   source   cars_road0..2, green_road, switch_pulse
//   cfg_ch    in    sink     index, data (always ready)
//
// One sweep is accepted per clock while out_ch is not stalled; its result passes
// through the input register, then counting/timing logic into the result register.
// The green-time path (count times per-car ms, add, limit, compare) sets the cycle.
// Reset clears counts, presence history, green road and phase start to zero.
// A stalled result holds in its register; the input register still fills
// behind it, after which in_ch.ready drops until out_ch.ready returns.
module vehicle_actuated_signal_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  vass_in_if.sink    in_ch,
  vass_out_if.source out_ch,
  vass_cfg_if.sink   cfg_ch
);

  vass_pkg::cfg_t       cfg;
  vass_pkg::stage_ctl_t ctl;
  vass_pkg::sweep_t     sweep;
  logic                 take;

  vass_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  vass_sense u_sense (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ch              (in_ch),
    .presence_threshold (cfg.presence_threshold),
    .take               (take),
    .ctl                (ctl),
    .sweep              (sweep)
  );

  vass_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .ctl    (ctl),
    .sweep  (sweep),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

### rtl/core/vass_cfg_regs.sv
// Configuration register file: threshold and green timing registers.
module vass_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  vass_cfg_if.sink          cfg_ch,
  output vass_pkg::cfg_t    cfg
);

  vass_pkg::cfg_t cfg_r;
  vass_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        vass_pkg::REG_PRESENCE_THRESHOLD:
          cfg_nxt.presence_threshold = cfg_ch.data[vass_pkg::RANGE_W-1:0];
        vass_pkg::REG_GREEN_BASE_MS:
          cfg_nxt.green_base_ms = cfg_ch.data[vass_pkg::MS_W-1:0];
        vass_pkg::REG_GREEN_PER_CAR_MS:
          cfg_nxt.green_per_car_ms = cfg_ch.data[vass_pkg::PCAR_W-1:0];
        vass_pkg::REG_GREEN_MAX_MS:
          cfg_nxt.green_max_ms = cfg_ch.data[vass_pkg::MS_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.presence_threshold <= vass_pkg::RST_PRESENCE_THRESHOLD;
      cfg_r.green_base_ms      <= vass_pkg::RST_GREEN_BASE_MS;
      cfg_r.green_per_car_ms   <= vass_pkg::RST_GREEN_PER_CAR_MS;
      cfg_r.green_max_ms       <= vass_pkg::RST_GREEN_MAX_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/vass_sense.sv
// Input register: captures one sweep and turns the six ranges into presence bits.
module vass_sense (
  input  logic                  clk,
  input  logic                  rst_n,
  vass_in_if.sink               in_ch,
  input  logic [vass_pkg::RANGE_W-1:0] presence_threshold,
  input  logic                  take,
  output vass_pkg::stage_ctl_t  ctl,
  output vass_pkg::sweep_t      sweep
);

  logic             s1_v_r;
  logic             s1_v_nxt;
  vass_pkg::sweep_t sweep_r;
  vass_pkg::sweep_t sweep_nxt;
  logic             accept;

  // the register frees up in the same cycle the result stage takes its item
  assign in_ch.ready = !s1_v_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    sweep_nxt.present[0] = in_ch.range_road0_entry < presence_threshold;
    sweep_nxt.present[1] = in_ch.range_road0_exit  < presence_threshold;
    sweep_nxt.present[2] = in_ch.range_road1_entry < presence_threshold;
    sweep_nxt.present[3] = in_ch.range_road1_exit  < presence_threshold;
    sweep_nxt.present[4] = in_ch.range_road2_entry < presence_threshold;
    sweep_nxt.present[5] = in_ch.range_road2_exit  < presence_threshold;
    sweep_nxt.now_ms     = in_ch.now_ms;
    s1_v_nxt             = accept || (s1_v_r && !take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sweep_r <= sweep_nxt;
    end
  end

  assign ctl.valid = s1_v_r;
  assign sweep     = sweep_r;

endmodule

### rtl/core/vass_core.sv
// Result stage: car counting, green time check, road advance and result register.
module vass_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vass_pkg::cfg_t        cfg,
  input  vass_pkg::stage_ctl_t  ctl,
  input  vass_pkg::sweep_t      sweep,
  output logic                  take,
  vass_out_if.source            out_ch
);

  localparam int unsigned PROD_W = vass_pkg::CNT_W + vass_pkg::PCAR_W;
  localparam int unsigned SUM_W  = vass_pkg::MS_W + 1;

  // sequencer state
  logic [vass_pkg::SENSORS-1:0] was_r;
  logic [vass_pkg::CNT_W-1:0]   cnt_r   [vass_pkg::ROADS];
  logic [vass_pkg::CNT_W-1:0]   cnt_nxt [vass_pkg::ROADS];
  logic [vass_pkg::ROAD_W-1:0]  road_r;
  logic [vass_pkg::ROAD_W-1:0]  road_nxt;
  logic [vass_pkg::MS_W-1:0]    start_r;

  // result register
  logic                         out_v_r;
  logic [vass_pkg::CNT_W-1:0]   res_cnt_r [vass_pkg::ROADS];
  logic [vass_pkg::ROAD_W-1:0]  res_road_r;
  logic                         res_sw_r;

  logic [vass_pkg::CNT_W-1:0]   cars;
  logic [PROD_W-1:0]            prod;
  logic [SUM_W-1:0]             sum;
  logic [vass_pkg::MS_W-1:0]    limit;
  logic [vass_pkg::MS_W-1:0]    elapsed;
  logic                         sw;
  logic [vass_pkg::ROAD_W-1:0]  road_adv;

  assign take = ctl.valid && (!out_v_r || out_ch.ready);

  // per road: entry edge first, then exit edge, each clamped
  always_comb begin
    logic [vass_pkg::CNT_W-1:0] c1;
    logic                       ent;
    logic                       ext;
    for (int r = 0; r < vass_pkg::ROADS; r++) begin
      ent = sweep.present[2*r]   && !was_r[2*r];
      ext = sweep.present[2*r+1] && !was_r[2*r+1];
      c1  = (ent && cnt_r[r] != vass_pkg::CNT_FULL) ?
            cnt_r[r] + 8'd1 : cnt_r[r];
      cnt_nxt[r] = (ext && c1 != vass_pkg::CNT_EMPTY) ? c1 - 8'd1 : c1;
    end
  end

  always_comb begin
    unique case (road_r)
      vass_pkg::ROAD_0: begin
        cars     = cnt_nxt[0];
        road_adv = vass_pkg::ROAD_1;
      end
      vass_pkg::ROAD_1: begin
        cars     = cnt_nxt[1];
        road_adv = vass_pkg::ROAD_2;
      end
      vass_pkg::ROAD_2: begin
        cars     = cnt_nxt[2];
        road_adv = vass_pkg::ROAD_0;
      end
      default: begin
        cars     = vass_pkg::CNT_EMPTY;
        road_adv = vass_pkg::ROAD_0;
      end
    endcase
  end

  always_comb begin
    prod    = {{vass_pkg::PCAR_W{1'b0}}, cars} *
              {{vass_pkg::CNT_W{1'b0}}, cfg.green_per_car_ms};
    sum     = {1'b0, cfg.green_base_ms} + {{(SUM_W - PROD_W){1'b0}}, prod};
    limit   = (sum > {1'b0, cfg.green_max_ms}) ? cfg.green_max_ms :
              sum[vass_pkg::MS_W-1:0];
    elapsed = sweep.now_ms - start_r;
    sw      = elapsed > limit;
    road_nxt = sw ? road_adv : road_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_r   <= '0;
      road_r  <= vass_pkg::ROAD_0;
      start_r <= '0;
      out_v_r <= 1'b0;
      for (int r = 0; r < vass_pkg::ROADS; r++) begin
        cnt_r[r] <= vass_pkg::CNT_EMPTY;
      end
    end else begin
      if (take) begin
        was_r  <= sweep.present;
        road_r <= road_nxt;
        if (sw) begin
          start_r <= sweep.now_ms;
        end
        for (int r = 0; r < vass_pkg::ROADS; r++) begin
          cnt_r[r] <= cnt_nxt[r];
        end
      end
      if (take) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_road_r <= road_nxt;
      res_sw_r   <= sw;
      for (int r = 0; r < vass_pkg::ROADS; r++) begin
        res_cnt_r[r] <= cnt_nxt[r];
      end
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.cars_road0   = res_cnt_r[0];
  assign out_ch.cars_road1   = res_cnt_r[1];
  assign out_ch.cars_road2   = res_cnt_r[2];
  assign out_ch.green_road   = res_road_r;
  assign out_ch.switch_pulse = res_sw_r;

endmodule

### sim/tb.sv
// Self-checking testbench for the vehicle-actuated signal sequencer.
import vass_pkg::*;

typedef struct packed {
  logic [SENSORS-1:0][RANGE_W-1:0] range_mm;  // entry at even index, exit at odd
  logic [MS_W-1:0]                 now_ms;
} sensor_sweep_t;

typedef struct packed {
  logic [ROADS-1:0][CNT_W-1:0] cars;
  logic [ROAD_W-1:0]           green_road;
  logic                        switch_pulse;
} signal_state_t;

typedef enum int {RUSH_IN, RUSH_OUT, CHURN, JUNK} traffic_mode_t;

class signal_scoreboard;
  cfg_t               regs;
  logic [SENSORS-1:0] was_present;
  logic [CNT_W-1:0]   counts [ROADS];
  logic [ROAD_W-1:0]  green;
  logic [MS_W-1:0]    phase_start;
  signal_state_t      owed_states [$];
  int                 errors;

  function new();
    regs.presence_threshold = RST_PRESENCE_THRESHOLD;
    regs.green_base_ms      = RST_GREEN_BASE_MS;
    regs.green_per_car_ms   = RST_GREEN_PER_CAR_MS;
    regs.green_max_ms       = RST_GREEN_MAX_MS;
    was_present = '0;
    foreach (counts[r]) counts[r] = CNT_EMPTY;
    green = ROAD_0;
    phase_start = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PRESENCE_THRESHOLD: regs.presence_threshold = data[RANGE_W-1:0];
      REG_GREEN_BASE_MS:      regs.green_base_ms      = data[MS_W-1:0];
      REG_GREEN_PER_CAR_MS:   regs.green_per_car_ms   = data[PCAR_W-1:0];
      REG_GREEN_MAX_MS:       regs.green_max_ms       = data[MS_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_sweep(sensor_sweep_t sw);
    logic [MS_W:0]    allowed_ms;
    logic [MS_W-1:0]  elapsed_ms;
    logic [CNT_W-1:0] green_cars;
    signal_state_t    st;
    int               road;
    for (int s = 0; s < SENSORS; s++) begin
      road = s / 2;
      if (sw.range_mm[s] < regs.presence_threshold) begin
        if (!was_present[s]) begin
          if (s % 2 == 0) begin
            if (counts[road] != CNT_FULL) counts[road] = counts[road] + 1'b1;
          end else if (counts[road] != CNT_EMPTY) begin
            counts[road] = counts[road] - 1'b1;
          end
        end
        was_present[s] = 1'b1;
      end else begin
        was_present[s] = 1'b0;
      end
    end
    green_cars = CNT_EMPTY;
    if (green < ROADS) green_cars = counts[green];
    // widen before the sum so a large base cannot wrap
    allowed_ms = {1'b0, regs.green_base_ms} + green_cars * regs.green_per_car_ms;
    if (allowed_ms > {1'b0, regs.green_max_ms}) allowed_ms = {1'b0, regs.green_max_ms};
    elapsed_ms = sw.now_ms - phase_start;
    st.switch_pulse = ({1'b0, elapsed_ms} > allowed_ms);
    if (st.switch_pulse) begin
      green = (green == ROAD_2 || green > ROAD_2) ? ROAD_0 : green + 1'b1;
      phase_start = sw.now_ms;
    end
    for (int r = 0; r < ROADS; r++) st.cars[r] = counts[r];
    st.green_road = green;
    owed_states.push_back(st);
  endfunction

  function void check_state(signal_state_t got);
    signal_state_t want;
    if (owed_states.size() == 0) begin
      $error("result with no sweep waiting: green_road %0d switch_pulse %0d",
             got.green_road, got.switch_pulse);
      errors++;
      return;
    end
    want = owed_states.pop_front();
    for (int r = 0; r < ROADS; r++) begin
      if (got.cars[r] !== want.cars[r]) begin
        $error("cars_road%0d expected %0d got %0d", r, want.cars[r], got.cars[r]);
        errors++;
      end
    end
    if (got.green_road !== want.green_road) begin
      $error("green_road expected %0d got %0d", want.green_road, got.green_road);
      errors++;
    end
    if (got.switch_pulse !== want.switch_pulse) begin
      $error("switch_pulse expected %0d got %0d", want.switch_pulse, got.switch_pulse);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_OFF      = 120;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [RANGE_W-1:0]   FAR = 16'hFFFF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   steady_left = 0;
  bit   squeeze_now = 1'b0;
  logic [SENSORS-1:0] last_lvl = '0;
  logic [MS_W-1:0]    clock_ms;

  signal_scoreboard sb;

  vass_in_if  in_ch ();
  vass_out_if out_ch ();
  vass_cfg_if cfg_ch ();

  vehicle_actuated_signal_sequencer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : watch_results
    signal_state_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.cars[0]      = out_ch.cars_road0;
      got.cars[1]      = out_ch.cars_road1;
      got.cars[2]      = out_ch.cars_road2;
      got.green_road   = out_ch.green_road;
      got.switch_pulse = out_ch.switch_pulse;
      sb.check_state(got);
    end
  end

  // result side: short stalls, a few long ones, calm stretches, one long hold-off
  initial begin : result_sink
    int r;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      r = $urandom_range(99);
      if (squeeze_now) begin
        squeeze_now = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (r < 60) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end else if (r < 90) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk);
      end else if (r < 95) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(40, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(80, 30)) @(posedge clk);
      end
    end
  end

  function automatic int sweep_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) steady_left = $urandom_range(60, 20);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic sensor_sweep_t sweep_of(logic [RANGE_W-1:0] r0e, logic [RANGE_W-1:0] r0x,
                                             logic [RANGE_W-1:0] r1e, logic [RANGE_W-1:0] r1x,
                                             logic [RANGE_W-1:0] r2e, logic [RANGE_W-1:0] r2x,
                                             logic [MS_W-1:0] now);
    sensor_sweep_t sw;
    sw.range_mm[0] = r0e;
    sw.range_mm[1] = r0x;
    sw.range_mm[2] = r1e;
    sw.range_mm[3] = r1x;
    sw.range_mm[4] = r2e;
    sw.range_mm[5] = r2x;
    sw.now_ms = now;
    return sw;
  endfunction

  function automatic logic [RANGE_W-1:0] reading_for(logic lvl, logic [RANGE_W-1:0] thr);
    int pick;
    pick = $urandom_range(9);
    if (lvl && thr != 0) begin
      if (pick == 0) return '0;
      if (pick == 1) return thr - 1'b1;
      return RANGE_W'($urandom_range(thr - 1, 0));
    end
    if (pick == 0) return '1;
    if (pick == 1) return thr;
    return RANGE_W'($urandom_range(16'hFFFF, thr));
  endfunction

  task automatic offer_sweep(input sensor_sweep_t sw);
    int gap;
    gap = sweep_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.range_road0_entry <= sw.range_mm[0];
    in_ch.range_road0_exit  <= sw.range_mm[1];
    in_ch.range_road1_entry <= sw.range_mm[2];
    in_ch.range_road1_exit  <= sw.range_mm[3];
    in_ch.range_road2_entry <= sw.range_mm[4];
    in_ch.range_road2_exit  <= sw.range_mm[5];
    in_ch.now_ms            <= sw.now_ms;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_sweep(sw);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // junk in the upper bits of the 16-bit registers must be dropped
  task automatic load_settings(input logic [RANGE_W-1:0] thr, input logic [MS_W-1:0] base,
                               input logic [PCAR_W-1:0] per_car, input logic [MS_W-1:0] max_ms);
    write_reg(REG_PRESENCE_THRESHOLD, {16'($urandom()), thr});
    write_reg(REG_GREEN_BASE_MS, base);
    write_reg(REG_GREEN_PER_CAR_MS, {16'($urandom()), per_car});
    write_reg(REG_GREEN_MAX_MS, max_ms);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.owed_states.size() != 0) @(posedge clk);
  endtask

  task automatic run_traffic(input traffic_mode_t mode, input int items);
    sensor_sweep_t sw;
    logic          lvl;
    bit            entry_side;
    for (int n = 0; n < items; n++) begin
      for (int s = 0; s < SENSORS; s++) begin
        entry_side = (s % 2 == 0);
        case (mode)
          RUSH_IN:  lvl = entry_side ? !last_lvl[s] : ($urandom_range(99) < 1);
          RUSH_OUT: lvl = !entry_side ? ($urandom_range(99) < 85 ? !last_lvl[s] : last_lvl[s])
                                      : ($urandom_range(99) < 5);
          default:  lvl = ($urandom_range(99) < 40);
        endcase
        last_lvl[s] = lvl;
        sw.range_mm[s] = (mode == JUNK) ? RANGE_W'($urandom())
                                        : reading_for(lvl, sb.regs.presence_threshold);
      end
      if (mode == JUNK) clock_ms = $urandom();
      else if ($urandom_range(99) < 3) clock_ms = clock_ms + $urandom();
      else clock_ms = clock_ms + $urandom_range(150);
      sw.now_ms = clock_ms;
      offer_sweep(sw);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.range_road0_entry = '0;
    in_ch.range_road0_exit  = '0;
    in_ch.range_road1_entry = '0;
    in_ch.range_road1_exit  = '0;
    in_ch.range_road2_entry = '0;
    in_ch.range_road2_exit  = '0;
    in_ch.now_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings; timing runs from zero, not from the first sweep
    offer_sweep(sweep_of(FAR, FAR, FAR, FAR, FAR, FAR, 32'd1));
    offer_sweep(sweep_of(16'd0, FAR, FAR, FAR, FAR, FAR, 32'd10));
    offer_sweep(sweep_of(16'd99, FAR, FAR, FAR, FAR, FAR, 32'd20));   // held presence
    offer_sweep(sweep_of(16'd100, FAR, FAR, FAR, FAR, FAR, 32'd30));  // at threshold: absent
    offer_sweep(sweep_of(16'd99, FAR, FAR, FAR, FAR, FAR, 32'd40));
    offer_sweep(sweep_of(FAR, FAR, FAR, 16'd0, 16'd50, FAR, 32'd50)); // exit on empty road
    offer_sweep(sweep_of(FAR, 16'd0, FAR, FAR, FAR, FAR, 32'd60));
    offer_sweep(sweep_of(FAR, FAR, FAR, FAR, 16'd0, 16'd0, 32'd70)); // entry then exit
    offer_sweep(sweep_of(FAR, FAR, FAR, FAR, FAR, FAR, 32'd7999));   // elapsed equals limit
    offer_sweep(sweep_of(FAR, FAR, FAR, FAR, FAR, FAR, 32'd8000));
    offer_sweep(sweep_of(FAR, FAR, FAR, FAR, FAR, FAR, 32'd14667));
    offer_sweep(sweep_of(FAR, FAR, FAR, FAR, FAR, FAR, 32'd22667));  // wrap back to road 0
    offer_sweep(sweep_of('0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF));
    offer_sweep(sweep_of('0, '0, '0, '0, '0, '0, 32'd100));          // timestamp wrapped
    offer_sweep(sweep_of(FAR, FAR, FAR, FAR, FAR, FAR, 32'd200));
    in_ch.valid <= 1'b0;

    // fill every road to saturation under a clamped green time
    wait_drained();
    load_settings(16'd2000, 32'd500, 16'd40, 32'd6000);
    clock_ms = 32'hFFFF_F000;
    squeeze_now = 1'b1;
    run_traffic(RUSH_IN, 580);

    // zero green time, everything but the top reading present
    wait_drained();
    write_reg(REG_UNUSED_LOW, $urandom());
    write_reg(REG_UNUSED_TOP, $urandom());
    load_settings(16'hFFFF, 32'd0, 16'd0, 32'd0);
    run_traffic(CHURN, 40);

    // green-time sum past 32 bits, nothing ever present
    wait_drained();
    load_settings(16'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    run_traffic(JUNK, 30);

    wait_drained();
    load_settings(16'd300, 32'd0, 16'd10, 32'hFFFF_FFFF);
    run_traffic(RUSH_OUT, 120);

    wait_drained();
    load_settings(RANGE_W'($urandom_range(4000, 1)), MS_W'($urandom_range(3000)),
                  PCAR_W'($urandom_range(200)), MS_W'($urandom_range(8000)));
    run_traffic(CHURN, 50);

    wait_drained();
    load_settings(RANGE_W'($urandom_range(4000, 1)), MS_W'($urandom_range(3000)),
                  PCAR_W'($urandom_range(200)), MS_W'($urandom_range(8000)));
    run_traffic(JUNK, 30);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.owed_states.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
